FILE: rtl/gls_pkg.sv
package gls_pkg;

  typedef enum logic [1:0] {
    MODE_REST   = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_LOCKED = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CTRL   = 2'd0,
    KIND_SAFETY = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_PROTOCOL_VERSION  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRANT_MAX_SECONDS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GRANT_CODE        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HEARTBEAT_CODE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_CODE         = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BENCH_CODE        = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SILENCE_CODE      = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_UNLOCK_CODE       = 3'd7;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  MIN_CTRL_BYTES = 8'd4;
  localparam logic [25:0] MS_PER_SEC     = 26'd1000;

  // seconds readout: clip the remaining time so the quotient never exceeds 255,
  // then floor(d / 1000) = (d * RECIP) >> RECIP_SHIFT, exact for d < 2^28 / 544
  localparam int unsigned DiffW       = 18;
  localparam logic [31:0] DIFF_SAT    = 32'd256000;
  localparam logic [DiffW-1:0] DIFF_CLIP = 18'd255999;
  localparam int unsigned RecipW      = 19;
  localparam logic [RecipW-1:0] RECIP = 19'd268436;
  localparam int unsigned RecipShift  = 28;
  localparam int unsigned ProdW       = DiffW + RecipW;

  typedef struct packed {
    logic [7:0]  protocol_version;
    logic [15:0] grant_max_seconds;
    logic [7:0]  grant_code;
    logic [7:0]  heartbeat_code;
    logic [7:0]  idle_code;
    logic [7:0]  bench_code;
    logic [7:0]  silence_code;
    logic [7:0]  unlock_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_count;
    logic [7:0]  version_byte;
    logic [7:0]  opcode;
    logic [15:0] argument;
    logic [7:0]  safety_byte;
  } req_t;

  // state right after one item, handed to the readout stages
  typedef struct packed {
    mode_e       mode;
    logic [7:0]  gesture;
    logic        redraw;
    logic [31:0] now_ms;
    logic [31:0] deadline_ms;
  } snap_t;

  typedef struct packed {
    logic [1:0] mode_out;
    logic [7:0] seconds_left;
    logic [7:0] gesture_out;
    logic       redraw;
  } rsp_t;

endpackage

FILE: rtl/gls_req_if.sv
interface gls_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_count;
  logic [7:0]  version_byte;
  logic [7:0]  opcode;
  logic [15:0] argument;
  logic [7:0]  safety_byte;

  modport source (
    output valid, kind, byte_count, version_byte, opcode, argument, safety_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, byte_count, version_byte, opcode, argument, safety_byte,
    output ready
  );
endinterface

FILE: rtl/gls_rsp_if.sv
interface gls_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode_out;
  logic [7:0] seconds_left;
  logic [7:0] gesture_out;
  logic       redraw;

  modport source (
    output valid, mode_out, seconds_left, gesture_out, redraw,
    input  ready
  );
  modport sink (
    input  valid, mode_out, seconds_left, gesture_out, redraw,
    output ready
  );
endinterface

FILE: rtl/gls_cfg_regs.sv
module gls_cfg_regs
  import gls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_version  <= 8'd1;
      cfg_q.grant_max_seconds <= 16'd30;
      cfg_q.grant_code        <= 8'd1;
      cfg_q.heartbeat_code    <= 8'd2;
      cfg_q.idle_code         <= 8'd0;
      cfg_q.bench_code        <= 8'd3;
      cfg_q.silence_code      <= 8'd1;
      cfg_q.unlock_code       <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROTOCOL_VERSION:  cfg_q.protocol_version  <= cfg_wdata_i[7:0];
        CFG_GRANT_MAX_SECONDS: cfg_q.grant_max_seconds <= cfg_wdata_i;
        CFG_GRANT_CODE:        cfg_q.grant_code        <= cfg_wdata_i[7:0];
        CFG_HEARTBEAT_CODE:    cfg_q.heartbeat_code    <= cfg_wdata_i[7:0];
        CFG_IDLE_CODE:         cfg_q.idle_code         <= cfg_wdata_i[7:0];
        CFG_BENCH_CODE:        cfg_q.bench_code        <= cfg_wdata_i[7:0];
        CFG_SILENCE_CODE:      cfg_q.silence_code      <= cfg_wdata_i[7:0];
        CFG_UNLOCK_CODE:       cfg_q.unlock_code       <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/gls_lease_core.sv
module gls_lease_core
  import gls_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  cfg_t  cfg_i,
  input  logic  req_valid_i,
  input  req_t  req_i,
  output logic  snap_vld_o,
  output snap_t snap_o
);

  logic        in_vld_q;
  req_t        in_q;
  mode_e       mode_q, mode_d;
  logic [7:0]  gesture_q, gesture_d;
  logic [31:0] now_q, now_d;
  logic [31:0] deadline_q, deadline_d;
  logic        snap_vld_q;
  snap_t       snap_q;

  logic        emit;
  logic        redraw;
  logic [15:0] ttl_s;
  logic [25:0] ttl_ms;
  logic [31:0] renew_ms;
  logic        is_grant;

  // grant and heartbeat share one constant multiply
  assign is_grant = (in_q.opcode == cfg_i.grant_code);
  always_comb begin
    if (is_grant && (in_q.argument < cfg_i.grant_max_seconds)) begin
      ttl_s = in_q.argument;
    end else begin
      ttl_s = cfg_i.grant_max_seconds;
    end
  end
  assign ttl_ms   = 26'(ttl_s) * MS_PER_SEC;
  assign renew_ms = now_q + 32'(ttl_ms);

  always_comb begin
    mode_d     = mode_q;
    gesture_d  = gesture_q;
    now_d      = now_q;
    deadline_d = deadline_q;
    emit       = 1'b0;
    redraw     = 1'b0;
    if (in_vld_q) begin
      unique case (in_q.kind)
        KIND_CTRL: begin
          if ((in_q.byte_count >= MIN_CTRL_BYTES) &&
              (in_q.version_byte == cfg_i.protocol_version)) begin
            emit = 1'b1;
            priority if (is_grant) begin
              if (mode_q != MODE_LOCKED) begin
                deadline_d = renew_ms;
                mode_d     = MODE_ACTIVE;
              end
            end else if (in_q.opcode == cfg_i.heartbeat_code) begin
              if (mode_q == MODE_ACTIVE) begin
                deadline_d = renew_ms;
              end
            end else if (in_q.opcode == cfg_i.idle_code) begin
              gesture_d = cfg_i.idle_code;
              redraw    = 1'b1;
            end else if (in_q.opcode == cfg_i.bench_code) begin
              redraw = 1'b1;
            end else begin
              if ((mode_q == MODE_ACTIVE) && (now_q < deadline_q)) begin
                gesture_d = in_q.opcode;
                redraw    = 1'b1;
              end
            end
          end
        end
        KIND_SAFETY: begin
          if (in_q.byte_count != 8'd0) begin
            emit = 1'b1;
            priority if (in_q.safety_byte == cfg_i.silence_code) begin
              mode_d     = MODE_LOCKED;
              deadline_d = 32'd0;
              gesture_d  = cfg_i.idle_code;
              redraw     = 1'b1;
            end else begin
              if (in_q.safety_byte == cfg_i.unlock_code) begin
                mode_d = MODE_REST;
              end
            end
          end
        end
        KIND_TICK: begin
          now_d = now_q + 32'd1;
          if ((mode_q == MODE_ACTIVE) && (now_d >= deadline_q)) begin
            mode_d    = MODE_REST;
            gesture_d = cfg_i.idle_code;
            emit      = 1'b1;
            redraw    = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      mode_q     <= MODE_REST;
      gesture_q  <= 8'd0;
      now_q      <= 32'd0;
      deadline_q <= 32'd0;
      snap_vld_q <= 1'b0;
    end else if (adv_i) begin
      in_vld_q   <= req_valid_i;
      mode_q     <= mode_d;
      gesture_q  <= gesture_d;
      now_q      <= now_d;
      deadline_q <= deadline_d;
      snap_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (req_valid_i) begin
        in_q <= req_i;
      end
      snap_q.mode        <= mode_d;
      snap_q.gesture     <= gesture_d;
      snap_q.redraw      <= redraw;
      snap_q.now_ms      <= now_d;
      snap_q.deadline_ms <= deadline_d;
    end
  end

  assign snap_vld_o = snap_vld_q;
  assign snap_o     = snap_q;

endmodule

FILE: rtl/gls_seconds.sv
module gls_seconds
  import gls_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  snap_vld_i,
  input  snap_t snap_i,
  output logic  rsp_vld_o,
  output rsp_t  rsp_o
);

  logic             clip_vld_q;
  mode_e            clip_mode_q;
  logic [7:0]       clip_gesture_q;
  logic             clip_redraw_q;
  logic [DiffW-1:0] clip_q, clip_d;
  logic [31:0]      diff;
  logic [ProdW-1:0] prod;
  logic             rsp_vld_q;
  rsp_t             rsp_q;

  assign diff = snap_i.deadline_ms - snap_i.now_ms;

  always_comb begin
    priority if (snap_i.deadline_ms <= snap_i.now_ms) begin
      clip_d = '0;
    end else if (diff >= DIFF_SAT) begin
      clip_d = DIFF_CLIP;
    end else begin
      clip_d = diff[DiffW-1:0];
    end
  end

  assign prod = ProdW'(clip_q) * ProdW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_vld_q <= 1'b0;
      rsp_vld_q  <= 1'b0;
    end else if (adv_i) begin
      clip_vld_q <= snap_vld_i;
      rsp_vld_q  <= clip_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      clip_mode_q        <= snap_i.mode;
      clip_gesture_q     <= snap_i.gesture;
      clip_redraw_q      <= snap_i.redraw;
      clip_q             <= clip_d;
      rsp_q.mode_out     <= clip_mode_q;
      rsp_q.seconds_left <= prod[RecipShift+7:RecipShift];
      rsp_q.gesture_out  <= clip_gesture_q;
      rsp_q.redraw       <= clip_redraw_q;
    end
  end

  assign rsp_vld_o = rsp_vld_q;
  assign rsp_o     = rsp_q;

endmodule

FILE: rtl/grant_lease_safety_controller.sv
// Lease controller for a safety-gated display. Takes control writes, safety
// writes and 1 ms ticks on req, one request per cycle unless rsp stalls, and
// returns at most one result per request on rsp. Each accepted request is
// registered, applied to mode, gesture, clock and deadline, then the remaining
// time is clipped and a reciprocal multiply turns it into whole seconds.
// Requests that produce no result leave an empty slot and do not reorder
// anything. The whole pipeline holds while a result waits on rsp. Write the
// configuration registers only with nothing in flight.
module grant_lease_safety_controller
  import gls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  gls_req_if.sink             req,
  gls_rsp_if.source           rsp
);

  cfg_t  cfg;
  req_t  req_pl;
  logic  adv;
  logic  snap_vld;
  snap_t snap;
  logic  rsp_vld;
  rsp_t  rsp_pl;

  assign adv       = !rsp_vld || rsp.ready;
  assign req.ready = adv;

  assign req_pl.kind         = req.kind;
  assign req_pl.byte_count   = req.byte_count;
  assign req_pl.version_byte = req.version_byte;
  assign req_pl.opcode       = req.opcode;
  assign req_pl.argument     = req.argument;
  assign req_pl.safety_byte  = req.safety_byte;

  gls_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gls_lease_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .cfg_i       (cfg),
    .req_valid_i (req.valid),
    .req_i       (req_pl),
    .snap_vld_o  (snap_vld),
    .snap_o      (snap)
  );

  gls_seconds u_sec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .snap_vld_i (snap_vld),
    .snap_i     (snap),
    .rsp_vld_o  (rsp_vld),
    .rsp_o      (rsp_pl)
  );

  assign rsp.valid        = rsp_vld;
  assign rsp.mode_out     = rsp_pl.mode_out;
  assign rsp.seconds_left = rsp_pl.seconds_left;
  assign rsp.gesture_out  = rsp_pl.gesture_out;
  assign rsp.redraw       = rsp_pl.redraw;

endmodule
